// ----- hw/rtl/lbp3_pkg.sv -----
// ----------------------------------------------------------------------------
// lbp3_pkg
// Shared types and constants of the 3x3 local binary pattern filter.
// ----------------------------------------------------------------------------
package lbp3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int PIX_W     = 8;
    localparam int CODE_W    = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int ROW_W     = 16;
    localparam int IROW_W    = ROW_W + 1;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CODE_W-1:0] LBP_WEIGHT [3][3] = '{
        '{8'd1,  8'd2,  8'd4},
        '{8'd8,  8'd0,  8'd16},
        '{8'd32, 8'd64, 8'd128}
    };

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [2:0][2:0] win_t;

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } bnd_t;

endpackage

// ----- hw/rtl/lbp_3x3_image_filter_top.sv -----
// ----------------------------------------------------------------------------
// lbp_3x3_image_filter_top
// Streaming 3x3 local binary pattern over raster-order grey pixels.
// Throughput: one item per cycle while m_tready does not stall the output, set
//   by the single line-store RAM (one read and one write of a column per cycle).
// Pipeline: the code of pixel k rides on item k + W + 1, which passes through
//   the line-store stage register and then the output register.
// Reset: width and height return to 256, all position counters to zero; the
//   line store is not cleared.
// ----------------------------------------------------------------------------
module lbp_3x3_image_filter_top
    import lbp3_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel_value
    input  logic              s_tuser,   // [0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] lbp_code
    output logic              m_tlast
);

    logic [WID_W-1:0]  width_reg, width_next;
    logic [ROW_W-1:0]  height_reg, height_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [IROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_emit_reg, s1_emit_next;
    bnd_t              s1_bnd_reg, s1_bnd_next;
    logic [COL_W-1:0]  s1_col_reg, s1_col_next;
    pix_t              s1_pix_reg, s1_pix_next;
    logic              fwd_valid_reg, fwd_valid_next;
    logic [2*PIX_W-1:0] fwd_data_reg, fwd_data_next;
    win_t              win_reg, win_next;

    logic              m_valid_reg, m_valid_next;
    logic [CODE_W-1:0] m_code_reg, m_code_next;
    logic              m_last_reg, m_last_next;

    logic [WID_W-1:0]  w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic              s_accept, s1_go, flush, in_over, active, emit;
    logic [WID_W-1:0]  in_col_inc, out_col_inc;
    bnd_t              bnd_now;
    pix_t              pix_now;
    logic [2*PIX_W-1:0] ram_rdata, line_data, ram_wdata;
    logic [CODE_W-1:0] code;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WID_W'(1);
        end else if (width_reg > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    assign s1_go    = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_accept = s_tvalid && s_tready;

    assign flush   = s_tuser;
    assign in_over = in_row_reg >= {1'b0, h_eff};
    assign active  = s_accept && (flush == in_over);
    assign emit    = !((in_row_reg == '0) || (in_row_reg == IROW_W'(1) && in_col_reg == '0));
    assign pix_now = flush ? '0 : s_tdata[PIX_W-1:0];

    assign in_col_inc  = {1'b0, in_col_reg} + WID_W'(1);
    assign out_col_inc = {1'b0, out_col_reg} + WID_W'(1);

    always_comb begin
        bnd_now.top_ok   = out_row_reg != '0;
        bnd_now.bot_ok   = ({1'b0, out_row_reg} + IROW_W'(1)) < {1'b0, h_eff};
        bnd_now.left_ok  = out_col_reg != '0;
        bnd_now.right_ok = out_col_inc < w_eff;
        bnd_now.last     = (out_row_reg == h_eff - ROW_W'(1)) &&
                           (out_col_inc == w_eff);
    end

    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_wdata[WID_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (active) begin
            if (in_col_inc >= w_eff) begin
                in_col_next = '0;
                in_row_next = in_row_reg + IROW_W'(1);
            end else begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
            if (emit) begin
                if (bnd_now.last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_inc >= w_eff) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    assign line_data = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign ram_wdata = {s1_pix_reg, line_data[2*PIX_W-1:PIX_W]};

    lbp3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_emit_next   = s1_emit_reg;
        s1_bnd_next    = s1_bnd_reg;
        s1_col_next    = s1_col_reg;
        s1_pix_next    = s1_pix_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_data_next  = fwd_data_reg;
        if (s_accept) begin
            s1_valid_next  = active;
            s1_emit_next   = emit;
            s1_bnd_next    = bnd_now;
            s1_col_next    = in_col_reg;
            s1_pix_next    = pix_now;
            fwd_valid_next = s1_go && (s1_col_reg == in_col_reg);
            fwd_data_next  = ram_wdata;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        for (int dr = 0; dr < 3; dr++) begin
            win_next[dr][0] = win_reg[dr][1];
            win_next[dr][1] = win_reg[dr][2];
        end
        win_next[0][2] = line_data[PIX_W-1:0];
        win_next[1][2] = line_data[2*PIX_W-1:PIX_W];
        win_next[2][2] = s1_pix_reg;
    end

    lbp3_code u_code (
        .win  (win_next),
        .bnd  (s1_bnd_reg),
        .code (code)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s1_go && s1_emit_reg) begin
            m_valid_next = 1'b1;
            m_code_next  = code;
            m_last_next  = s1_bnd_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WID_W'(256);
            height_reg    <= ROW_W'(256);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_emit_reg  <= s1_emit_next;
        s1_bnd_reg   <= s1_bnd_next;
        s1_col_reg   <= s1_col_next;
        s1_pix_reg   <= s1_pix_next;
        fwd_data_reg <= fwd_data_next;
        m_code_reg   <= m_code_next;
        m_last_reg   <= m_last_next;
        if (s1_go) begin
            win_reg <= win_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_code_reg;
    assign m_tlast  = m_last_reg;

    a_fwd_column_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_valid_reg |-> (s1_col_reg == '0))
        else $error("line store bypass taken away from column zero");

    a_columns_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, in_col_reg} < w_eff) && ({1'b0, out_col_reg} < w_eff))
        else $error("column counter beyond image width");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stalled item lost from line store stage");

endmodule

// ----- hw/rtl/lbp3_ram.sv -----
// ----------------------------------------------------------------------------
// lbp3_ram
// Generic single-clock RAM, one write and one read port, registered read
// (read-first on a same-address collision).
// ----------------------------------------------------------------------------
module lbp3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/lbp3_code.sv -----
// ----------------------------------------------------------------------------
// lbp3_code
// Local binary pattern of one 3x3 window, border neighbours masked.
// ----------------------------------------------------------------------------
module lbp3_code
    import lbp3_pkg::*;
(
    input  win_t              win,
    input  bnd_t              bnd,
    output logic [CODE_W-1:0] code
);

    always_comb begin
        code = '0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                if ((dr != 0 || bnd.top_ok) && (dr != 2 || bnd.bot_ok) &&
                    (dc != 0 || bnd.left_ok) && (dc != 2 || bnd.right_ok) &&
                    (win[dr][dc] > win[1][1])) begin
                    code = code | LBP_WEIGHT[dr][dc];
                end
            end
        end
    end

endmodule
